// ----- hw/rtl/psu_pkg.sv -----
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the png scanline unfilter: register indexes,
// reset values, filter type codes and the request handed between stages.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 4096;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int BYTE_W = 8;
  localparam int BPP_W  = 4;
  localparam int RLEN_W = 13;
  localparam int ROWS_W = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] CFG_BPP        = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROW_LENGTH = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_ROWS = 2'd2;

  localparam logic [BPP_W-1:0]  BPP_RESET        = 4'd4;
  localparam logic [RLEN_W-1:0] ROW_LENGTH_RESET = 13'd4096;
  localparam logic [ROWS_W-1:0] IMAGE_ROWS_RESET = 16'd1;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // what a request leaves behind once it has passed the sequencer
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic [2:0]        filter;
    logic              rend;
    logic              iend;
    logic              first_row;
    logic              use_left;
  } item_t;

endpackage

// ----- hw/rtl/psu_ram.sv -----
// ----------------------------------------------------------------------------
// psu_ram
// Generic single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/psu_sequencer.sv -----
// ----------------------------------------------------------------------------
// psu_sequencer
// Configuration registers, column and row counters and the abort state.
// Classifies each accepted byte, issues the row store read and holds the
// request until the reconstruction stage takes it.
// ----------------------------------------------------------------------------
module psu_sequencer #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES,
  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  localparam int HIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           stream_valid,
  output logic                           stream_ready,
  input  logic [psu_pkg::BYTE_W-1:0]     stream_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psu_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [psu_pkg::CFG_DW-1:0]     cfg_data,
  input  logic                           advance,
  output psu_pkg::item_t                 item,
  output logic [AW-1:0]                  item_x,
  output logic [HIW-1:0]                 item_bpp_idx,
  output logic                           rd_en,
  output logic [AW-1:0]                  rd_addr
);

  localparam int CW = $clog2(MAX_ROW_BYTES + 2);
  localparam int LW = ((CW > psu_pkg::RLEN_W) ? CW : psu_pkg::RLEN_W) + 1;

  logic [psu_pkg::BPP_W-1:0]  bpp;
  logic [psu_pkg::RLEN_W-1:0] row_length;
  logic [psu_pkg::ROWS_W-1:0] image_rows;

  logic [CW-1:0]                 column_count;
  logic [CW-1:0]                 column_count_next;
  logic [psu_pkg::ROWS_W-1:0]    row_count;
  logic [psu_pkg::ROWS_W-1:0]    row_count_next;
  logic                          image_failed;
  logic                          image_failed_next;
  logic [2:0]                    row_filter;
  logic [2:0]                    row_filter_next;

  logic                          accept;
  logic [CW-1:0]                 x_full;
  logic [AW-1:0]                 x;
  logic [LW-1:0]                 len_eff;
  logic [psu_pkg::ROWS_W-1:0]    rows_eff;
  logic [psu_pkg::ROWS_W-1:0]    row_inc;
  logic [psu_pkg::BPP_W-1:0]     bpp_eff;
  logic                          rend;
  logic                          iend;
  psu_pkg::item_t                item_next;

  assign cfg_ready    = !rst;
  assign stream_ready = !rst && (!item.valid || advance);
  assign accept       = stream_valid && stream_ready;

  always_comb begin
    if (bpp == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bpp > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
      bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp;
    end

    if (row_length == '0) begin
      len_eff = LW'(1);
    end else if (LW'(row_length) > LW'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = LW'(row_length);
    end

    rows_eff = (image_rows == '0) ? psu_pkg::ROWS_W'(1) : image_rows;

    x_full = column_count - CW'(1);
    if (LW'(x_full) >= LW'(MAX_ROW_BYTES)) begin
      x = AW'(MAX_ROW_BYTES - 1);
    end else begin
      x = x_full[AW-1:0];
    end
    rend    = (LW'(x) + LW'(1)) >= len_eff;
    row_inc = row_count + psu_pkg::ROWS_W'(1);
    iend    = rend && ((row_inc >= rows_eff) || (row_inc == '0));
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    image_failed_next = image_failed;
    row_filter_next   = row_filter;

    item_next.valid     = 1'b1;
    item_next.kind      = psu_pkg::KIND_NONE;
    item_next.data      = stream_byte;
    item_next.filter    = row_filter;
    item_next.rend      = rend;
    item_next.iend      = iend;
    item_next.first_row = (row_count == '0);
    item_next.use_left  = LW'(x) >= LW'(bpp_eff);

    if (column_count == '0) begin
      // filter type byte
      column_count_next = CW'(1);
      if (!image_failed) begin
        if (stream_byte > {5'd0, psu_pkg::FILT_PAETH}) begin
          image_failed_next = 1'b1;
          item_next.kind    = psu_pkg::KIND_ERR;
        end else begin
          row_filter_next = stream_byte[2:0];
        end
      end
    end else begin
      if (rend) begin
        column_count_next = '0;
        row_count_next    = row_inc;
      end else begin
        column_count_next = CW'(x) + CW'(2);
      end
      if (image_failed) begin
        if (iend) begin
          row_count_next    = '0;
          image_failed_next = 1'b0;
        end
      end else begin
        item_next.kind = psu_pkg::KIND_DATA;
        if (iend) begin
          row_count_next = '0;
        end
      end
    end
  end

  assign rd_en   = accept && (column_count != '0);
  assign rd_addr = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp          <= psu_pkg::BPP_RESET;
      row_length   <= psu_pkg::ROW_LENGTH_RESET;
      image_rows   <= psu_pkg::IMAGE_ROWS_RESET;
      column_count <= '0;
      row_count    <= '0;
      image_failed <= 1'b0;
      row_filter   <= psu_pkg::FILT_NONE;
      item.valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psu_pkg::CFG_BPP:        bpp        <= cfg_data[psu_pkg::BPP_W-1:0];
          psu_pkg::CFG_ROW_LENGTH: row_length <= cfg_data[psu_pkg::RLEN_W-1:0];
          psu_pkg::CFG_IMAGE_ROWS: image_rows <= cfg_data[psu_pkg::ROWS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        image_failed <= image_failed_next;
        row_filter   <= row_filter_next;
        item         <= item_next;
        item_x       <= x;
        item_bpp_idx <= HIW'(bpp_eff - psu_pkg::BPP_W'(1));
      end else if (advance) begin
        item.valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/psu_recon.sv -----
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruction stage: neighbour histories, filter predictors, row store
// write-back and the output register.
// ----------------------------------------------------------------------------
module psu_recon #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES,
  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
  localparam int HIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  psu_pkg::item_t             item,
  input  logic [AW-1:0]              item_x,
  input  logic [HIW-1:0]             item_bpp_idx,
  input  logic [psu_pkg::BYTE_W-1:0] rd_data,
  output logic                       advance,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [psu_pkg::BYTE_W-1:0] wr_data,
  output logic                       pixel_valid,
  input  logic                       pixel_ready,
  output logic [psu_pkg::BYTE_W-1:0] pixel_byte,
  output logic                       row_end,
  output logic                       image_end,
  output logic                       bad_filter
);

  logic [psu_pkg::BYTE_W-1:0] left_hist [MAX_PIXEL_BYTES];
  logic [psu_pkg::BYTE_W-1:0] upleft_hist [MAX_PIXEL_BYTES];

  logic [7:0]        a;
  logic [7:0]        b;
  logic [7:0]        c;
  logic [8:0]        ab_sum;
  logic signed [9:0] da;
  logic signed [9:0] db;
  logic signed [9:0] dc;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        paeth;
  logic [7:0]        pred;
  logic [7:0]        val;

  assign advance = item.valid && (!pixel_valid || pixel_ready);

  always_comb begin
    a = item.use_left ? left_hist[item_bpp_idx] : 8'd0;
    c = item.use_left ? upleft_hist[item_bpp_idx] : 8'd0;
    b = item.first_row ? 8'd0 : rd_data;

    ab_sum = {1'b0, a} + {1'b0, b};

    // distances from a+b-c to a, b and c
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({1'b0, ab_sum}) - $signed({1'b0, c, 1'b0});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end

    case (item.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth;
      default:             pred = 8'd0;
    endcase

    val = item.data + pred;
  end

  assign wr_en   = advance && (item.kind == psu_pkg::KIND_DATA);
  assign wr_addr = item_x;
  assign wr_data = val;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= '0;
        upleft_hist[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]   <= left_hist[i-1];
        upleft_hist[i] <= upleft_hist[i-1];
      end
      left_hist[0]   <= val;
      upleft_hist[0] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      case (item.kind)
        psu_pkg::KIND_DATA: begin
          pixel_valid <= 1'b1;
          pixel_byte  <= val;
          row_end     <= item.rend;
          image_end   <= item.iend;
          bad_filter  <= 1'b0;
        end
        psu_pkg::KIND_ERR: begin
          pixel_valid <= 1'b1;
          pixel_byte  <= '0;
          row_end     <= 1'b0;
          image_end   <= 1'b0;
          bad_filter  <= 1'b1;
        end
        default: begin
          pixel_valid <= 1'b0;
        end
      endcase
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/png_scanline_unfilter_top.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// Reverses the png scanline filters on an inflated byte stream.
// ----------------------------------------------------------------------------
// The stream channel takes one filtered byte per request: a filter type byte
// and then row_length data bytes for each row, image_rows rows per image.
// The pixel channel gives one reconstructed byte per data byte, with row_end
// and image_end on the last byte of a row and of an image. A filter type
// above four gives one request with bad_filter set; the rest of that image
// is consumed without output and the next image starts clean.
// A stream byte passes the request register and then the output register.
// One byte is taken every cycle while the pixel side does not stall; filter
// bytes pass through the same slot and give no output but for a bad filter
// type. If the pixel side stalls, the output register holds and the stream
// side takes one more byte into the pipeline register, then waits.
// Registers are written over the cfg channel, index 0 bytes per pixel,
// 1 row length, 2 image rows; the user must write them only while no image
// is in progress, and the block itself does not enforce it.
// Reset clears counters and the pipeline and restores register defaults;
// no clearing pass is needed: a first row ignores what the row store gives.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       stream_valid,
  output logic                       stream_ready,
  input  logic [psu_pkg::BYTE_W-1:0] stream_byte,
  output logic                       pixel_valid,
  input  logic                       pixel_ready,
  output logic [psu_pkg::BYTE_W-1:0] pixel_byte,
  output logic                       row_end,
  output logic                       image_end,
  output logic                       bad_filter,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psu_pkg::CFG_IW-1:0] cfg_index,
  input  logic [psu_pkg::CFG_DW-1:0] cfg_data
);

  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int HIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  psu_pkg::item_t             item;
  logic [AW-1:0]              item_x;
  logic [HIW-1:0]             item_bpp_idx;
  logic                       advance;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [psu_pkg::BYTE_W-1:0] rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [psu_pkg::BYTE_W-1:0] wr_data;

  psu_sequencer #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_sequencer (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_ready (stream_ready),
    .stream_byte  (stream_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .advance      (advance),
    .item         (item),
    .item_x       (item_x),
    .item_bpp_idx (item_bpp_idx),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  psu_ram #(
    .WIDTH (psu_pkg::BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psu_recon #(
    .MAX_ROW_BYTES   (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
  ) u_recon (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_x       (item_x),
    .item_bpp_idx (item_bpp_idx),
    .rd_data      (rd_data),
    .advance      (advance),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_byte   (pixel_byte),
    .row_end      (row_end),
    .image_end    (image_end),
    .bad_filter   (bad_filter)
  );

endmodule

// ----- hw/rtl/psu_checker.sv -----
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks of the png scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       stream_valid,
  input logic                       stream_ready,
  input logic                       pixel_valid,
  input logic                       pixel_ready,
  input logic [psu_pkg::BYTE_W-1:0] pixel_byte,
  input logic                       row_end,
  input logic                       image_end,
  input logic                       bad_filter
);

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_byte) &&
      $stable(row_end) && $stable(image_end) && $stable(bad_filter))
    else $error("pixel request changed while stalled");

  // error requests carry nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && bad_filter |-> pixel_byte == '0 && !row_end && !image_end)
    else $error("error request with payload");

  // an image ends on a row end
  a_image_row: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && image_end |-> row_end)
    else $error("image end without row end");

  // output empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel request after reset");

  // a fresh output follows an accepted stream request through the request register
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(stream_valid && stream_ready, 2))
    else $error("pixel request without a stream request");

endmodule

bind png_scanline_unfilter_top psu_checker u_psu_checker (
  .clk          (clk),
  .rst          (rst),
  .stream_valid (stream_valid),
  .stream_ready (stream_ready),
  .pixel_valid  (pixel_valid),
  .pixel_ready  (pixel_ready),
  .pixel_byte   (pixel_byte),
  .row_end      (row_end),
  .image_end    (image_end),
  .bad_filter   (bad_filter)
);
